### rtl/core/mt_pkg.sv
// Shared types, constants and the tempering function of the MT19937 generator.
package mt_pkg;

  localparam int unsigned NumWords = 624;
  localparam int unsigned ShiftPos = 397;
  localparam int unsigned AddrW    = 10;

  localparam logic [31:0] LinMult   = 32'd1812433253;
  localparam logic [31:0] KeyMult1  = 32'd1664525;
  localparam logic [31:0] KeyMult2  = 32'd1566083941;
  localparam logic [31:0] KeyBase   = 32'd19650218;
  localparam logic [31:0] MatrixA   = 32'h9908b0df;
  localparam logic [31:0] TemperB   = 32'h9d2c5680;
  localparam logic [31:0] TemperC   = 32'hefc60000;
  localparam logic [31:0] UpperMask = 32'h80000000;
  localparam logic [31:0] LowerMask = 32'h7fffffff;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(NumWords - 1);
  localparam logic [AddrW-1:0] EndPos   = AddrW'(NumWords);

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OpNext    = 2'd0;
  localparam logic [1:0] OpSeedLin = 2'd1;
  localparam logic [1:0] OpSeedKey = 2'd2;

  // Controller states.
  typedef enum logic [4:0] {
    StIdle,
    StLinFirst,
    StLinStep,
    StLinDone,
    StK1Init,
    StK1Rd,
    StK1Wr,
    StK1Wrap,
    StK2Init,
    StK2Rd,
    StK2Wr,
    StK2Wrap,
    StKeyEnd,
    StTwPre,
    StTwP2,
    StTwB,
    StTwC,
    StRdPos,
    StOut,
    StNoSeed
  } ctrl_state_e;

  // Datapath commands, one per cycle.
  typedef enum logic [4:0] {
    CmdNone,
    CmdCapture,
    CmdLinFirst,
    CmdLinStep,
    CmdLinDone,
    CmdK1Init,
    CmdK1Rd,
    CmdK1Wr,
    CmdWrap,
    CmdK2Init,
    CmdK2Rd,
    CmdK2Wr,
    CmdKeyEnd,
    CmdTwPre,
    CmdTwP2,
    CmdTwB,
    CmdTwC,
    CmdRdPos,
    CmdOutLoad,
    CmdOutNoSeed
  } dp_cmd_e;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic seeded;
    logic pos_end;
    logic i_last;
    logic k_last;
    logic k_zero;
    logic key_mode;
    logic out_busy;
  } dp_status_t;

  // Standard MT19937 output tempering.
  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

### rtl/core/mt_ctrl.sv
// Sequencing state machine of the MT19937 generator.
module mt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           in_op_i,
  output logic                 in_ready_o,
  input  mt_pkg::dp_status_t   status_i,
  output mt_pkg::dp_cmd_e      cmd_o
);

  mt_pkg::ctrl_state_e state_q, state_d;
  logic in_xfer;

  assign in_xfer = in_valid_i && (state_q == mt_pkg::StIdle);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mt_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mt_pkg::StIdle: begin
        if (in_xfer) begin
          case (in_op_i)
            mt_pkg::OpNext: begin
              if (!status_i.seeded) begin
                state_d = mt_pkg::StNoSeed;
              end else if (status_i.pos_end) begin
                state_d = mt_pkg::StTwPre;
              end else begin
                state_d = mt_pkg::StRdPos;
              end
            end
            mt_pkg::OpSeedLin, mt_pkg::OpSeedKey: state_d = mt_pkg::StLinFirst;
            default: state_d = mt_pkg::StIdle;
          endcase
        end
      end
      mt_pkg::StLinFirst: state_d = mt_pkg::StLinStep;
      mt_pkg::StLinStep: begin
        if (status_i.i_last) begin
          state_d = status_i.key_mode ? mt_pkg::StK1Init : mt_pkg::StLinDone;
        end
      end
      mt_pkg::StLinDone: state_d = mt_pkg::StIdle;
      mt_pkg::StK1Init:  state_d = mt_pkg::StK1Rd;
      mt_pkg::StK1Rd:    state_d = mt_pkg::StK1Wr;
      mt_pkg::StK1Wr: begin
        if (status_i.i_last) begin
          state_d = mt_pkg::StK1Wrap;
        end else if (status_i.k_last) begin
          state_d = mt_pkg::StK2Init;
        end else begin
          state_d = mt_pkg::StK1Rd;
        end
      end
      mt_pkg::StK1Wrap: state_d = status_i.k_zero ? mt_pkg::StK2Init : mt_pkg::StK1Rd;
      mt_pkg::StK2Init: state_d = mt_pkg::StK2Rd;
      mt_pkg::StK2Rd:   state_d = mt_pkg::StK2Wr;
      mt_pkg::StK2Wr: begin
        if (status_i.i_last) begin
          state_d = mt_pkg::StK2Wrap;
        end else if (status_i.k_last) begin
          state_d = mt_pkg::StKeyEnd;
        end else begin
          state_d = mt_pkg::StK2Rd;
        end
      end
      mt_pkg::StK2Wrap: state_d = status_i.k_zero ? mt_pkg::StKeyEnd : mt_pkg::StK2Rd;
      mt_pkg::StKeyEnd: state_d = mt_pkg::StIdle;
      mt_pkg::StTwPre:  state_d = mt_pkg::StTwP2;
      mt_pkg::StTwP2:   state_d = mt_pkg::StTwB;
      mt_pkg::StTwB:    state_d = mt_pkg::StTwC;
      mt_pkg::StTwC:    state_d = status_i.i_last ? mt_pkg::StRdPos : mt_pkg::StTwB;
      mt_pkg::StRdPos:  state_d = mt_pkg::StOut;
      mt_pkg::StOut: begin
        if (!status_i.out_busy) begin
          state_d = mt_pkg::StIdle;
        end
      end
      mt_pkg::StNoSeed: begin
        if (!status_i.out_busy) begin
          state_d = mt_pkg::StIdle;
        end
      end
      default: state_d = mt_pkg::StIdle;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o = (state_q == mt_pkg::StIdle);
    cmd_o      = mt_pkg::CmdNone;
    case (state_q)
      mt_pkg::StIdle: begin
        if (in_xfer) begin
          cmd_o = mt_pkg::CmdCapture;
        end
      end
      mt_pkg::StLinFirst: cmd_o = mt_pkg::CmdLinFirst;
      mt_pkg::StLinStep:  cmd_o = mt_pkg::CmdLinStep;
      mt_pkg::StLinDone:  cmd_o = mt_pkg::CmdLinDone;
      mt_pkg::StK1Init:   cmd_o = mt_pkg::CmdK1Init;
      mt_pkg::StK1Rd:     cmd_o = mt_pkg::CmdK1Rd;
      mt_pkg::StK1Wr:     cmd_o = mt_pkg::CmdK1Wr;
      mt_pkg::StK1Wrap:   cmd_o = mt_pkg::CmdWrap;
      mt_pkg::StK2Init:   cmd_o = mt_pkg::CmdK2Init;
      mt_pkg::StK2Rd:     cmd_o = mt_pkg::CmdK2Rd;
      mt_pkg::StK2Wr:     cmd_o = mt_pkg::CmdK2Wr;
      mt_pkg::StK2Wrap:   cmd_o = mt_pkg::CmdWrap;
      mt_pkg::StKeyEnd:   cmd_o = mt_pkg::CmdKeyEnd;
      mt_pkg::StTwPre:    cmd_o = mt_pkg::CmdTwPre;
      mt_pkg::StTwP2:     cmd_o = mt_pkg::CmdTwP2;
      mt_pkg::StTwB:      cmd_o = mt_pkg::CmdTwB;
      mt_pkg::StTwC:      cmd_o = mt_pkg::CmdTwC;
      mt_pkg::StRdPos:    cmd_o = mt_pkg::CmdRdPos;
      mt_pkg::StOut: begin
        if (!status_i.out_busy) begin
          cmd_o = mt_pkg::CmdOutLoad;
        end
      end
      mt_pkg::StNoSeed: begin
        if (!status_i.out_busy) begin
          cmd_o = mt_pkg::CmdOutNoSeed;
        end
      end
      default: cmd_o = mt_pkg::CmdNone;
    endcase
  end

endmodule

### rtl/core/mt_dp.sv
// Datapath of the MT19937 generator: state memory, counters, multiplier, output register.
module mt_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mt_pkg::dp_cmd_e      cmd_i,
  input  logic [1:0]           in_op_i,
  input  logic [63:0]          in_seed_i,
  output mt_pkg::dp_status_t   status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [31:0]          out_word_o,
  output logic                 out_ok_o
);

  localparam int unsigned AW = mt_pkg::AddrW;

  // State memory, one write and one registered read port.
  logic [31:0]   mem_q [mt_pkg::NumWords];
  logic [31:0]   rdata_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata;

  // Control and payload registers.
  logic          seeded_q, seeded_d;
  logic [AW-1:0] pos_q, pos_d;
  logic          out_valid_q, out_valid_d;
  logic [31:0]   out_word_q, out_word_d;
  logic          out_ok_q, out_ok_d;
  logic [AW-1:0] i_q, i_d, k_q, k_d;
  logic          j_q, j_d;
  logic          klen2_q, klen2_d;
  logic          key_mode_q, key_mode_d;
  logic [63:0]   key_q, key_d;
  logic [31:0]   p_q, p_d, cur_q, cur_d, nxt_q, nxt_d;

  logic [31:0]   mul_src, mul_k, prod, key_word, y, twist_val;
  logic [AW:0]   add397, add2;
  logic [AW-1:0] i_plus1, i_plus397, i_plus2;

  // Shared multiplier on the previous word, keeping the low 32 bits.
  always_comb begin
    case (cmd_i)
      mt_pkg::CmdK1Wr: mul_k = mt_pkg::KeyMult1;
      mt_pkg::CmdK2Wr: mul_k = mt_pkg::KeyMult2;
      default:         mul_k = mt_pkg::LinMult;
    endcase
  end
  assign mul_src   = p_q ^ (p_q >> 30);
  assign prod      = mul_src * mul_k;

  // Wrapped address arithmetic for the twist.
  assign i_plus1   = i_q + 1'b1;
  assign add397    = {1'b0, i_q} + (AW + 1)'(mt_pkg::ShiftPos);
  assign i_plus397 = (add397 >= (AW + 1)'(mt_pkg::NumWords)) ?
                     AW'(add397 - (AW + 1)'(mt_pkg::NumWords)) : add397[AW-1:0];
  assign add2      = {1'b0, i_q} + (AW + 1)'(2);
  assign i_plus2   = (add2 >= (AW + 1)'(mt_pkg::NumWords)) ?
                     AW'(add2 - (AW + 1)'(mt_pkg::NumWords)) : add2[AW-1:0];

  assign key_word  = j_q ? key_q[63:32] : key_q[31:0];
  assign y         = (cur_q & mt_pkg::UpperMask) | (nxt_q & mt_pkg::LowerMask);
  assign twist_val = rdata_q ^ (y >> 1) ^ (y[0] ? mt_pkg::MatrixA : 32'd0);

  // Command decode.
  always_comb begin
    we          = 1'b0;
    waddr       = i_q;
    wdata       = p_q;
    raddr       = pos_q;
    seeded_d    = seeded_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;
    out_ok_d    = out_ok_q;
    i_d         = i_q;
    k_d         = k_q;
    j_d         = j_q;
    klen2_d     = klen2_q;
    key_mode_d  = key_mode_q;
    key_d       = key_q;
    p_d         = p_q;
    cur_d       = cur_q;
    nxt_d       = nxt_q;
    case (cmd_i)
      mt_pkg::CmdCapture: begin
        key_d      = in_seed_i;
        klen2_d    = |in_seed_i[63:32];
        key_mode_d = (in_op_i == mt_pkg::OpSeedKey);
      end
      mt_pkg::CmdLinFirst: begin
        we    = 1'b1;
        waddr = '0;
        wdata = key_mode_q ? mt_pkg::KeyBase : key_q[31:0];
        p_d   = wdata;
        i_d   = AW'(1);
      end
      mt_pkg::CmdLinStep: begin
        we    = 1'b1;
        wdata = prod + {{(32 - AW){1'b0}}, i_q};
        p_d   = wdata;
        i_d   = i_plus1;
      end
      mt_pkg::CmdLinDone: begin
        seeded_d = 1'b1;
        pos_d    = mt_pkg::EndPos;
      end
      mt_pkg::CmdK1Init: begin
        // The first mixing step uses word 0, which holds the base seed, as its previous word.
        p_d = mt_pkg::KeyBase;
        i_d = AW'(1);
        j_d = 1'b0;
        k_d = mt_pkg::EndPos;
      end
      mt_pkg::CmdK1Rd, mt_pkg::CmdK2Rd: begin
        raddr = i_q;
      end
      mt_pkg::CmdK1Wr: begin
        we    = 1'b1;
        wdata = (rdata_q ^ prod) + key_word + {31'd0, j_q};
        p_d   = wdata;
        i_d   = (i_q == mt_pkg::LastAddr) ? AW'(1) : i_plus1;
        j_d   = klen2_q && !j_q;
        k_d   = k_q - 1'b1;
      end
      mt_pkg::CmdWrap: begin
        we    = 1'b1;
        waddr = '0;
        wdata = p_q;
      end
      mt_pkg::CmdK2Init: begin
        k_d = mt_pkg::LastAddr;
      end
      mt_pkg::CmdK2Wr: begin
        we    = 1'b1;
        wdata = (rdata_q ^ prod) - {{(32 - AW){1'b0}}, i_q};
        p_d   = wdata;
        i_d   = (i_q == mt_pkg::LastAddr) ? AW'(1) : i_plus1;
        k_d   = k_q - 1'b1;
      end
      mt_pkg::CmdKeyEnd: begin
        we       = 1'b1;
        waddr    = '0;
        wdata    = mt_pkg::UpperMask;
        seeded_d = 1'b1;
        pos_d    = mt_pkg::EndPos;
      end
      mt_pkg::CmdTwPre: begin
        raddr = '0;
        i_d   = '0;
      end
      mt_pkg::CmdTwP2: begin
        cur_d = rdata_q;
        raddr = AW'(1);
      end
      mt_pkg::CmdTwB: begin
        nxt_d = rdata_q;
        raddr = i_plus397;
      end
      mt_pkg::CmdTwC: begin
        we    = 1'b1;
        wdata = twist_val;
        cur_d = nxt_q;
        raddr = i_plus2;
        i_d   = i_plus1;
        if (i_q == mt_pkg::LastAddr) begin
          pos_d = '0;
        end
      end
      mt_pkg::CmdRdPos: begin
        raddr = pos_q;
      end
      mt_pkg::CmdOutLoad: begin
        out_valid_d = 1'b1;
        out_word_d  = mt_pkg::temper(rdata_q);
        out_ok_d    = 1'b1;
        pos_d       = pos_q + 1'b1;
      end
      mt_pkg::CmdOutNoSeed: begin
        out_valid_d = 1'b1;
        out_word_d  = '0;
        out_ok_d    = 1'b0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Memory array.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q    <= 1'b0;
      pos_q       <= mt_pkg::EndPos;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      k_q         <= '0;
      j_q         <= 1'b0;
    end else begin
      seeded_q    <= seeded_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      i_q         <= i_d;
      k_q         <= k_d;
      j_q         <= j_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
    out_ok_q   <= out_ok_d;
    klen2_q    <= klen2_d;
    key_mode_q <= key_mode_d;
    key_q      <= key_d;
    p_q        <= p_d;
    cur_q      <= cur_d;
    nxt_q      <= nxt_d;
  end

  assign status_o.seeded   = seeded_q;
  assign status_o.pos_end  = (pos_q == mt_pkg::EndPos);
  assign status_o.i_last   = (i_q == mt_pkg::LastAddr);
  assign status_o.k_last   = (k_q == AW'(1));
  assign status_o.k_zero   = (k_q == '0);
  assign status_o.key_mode = key_mode_q;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_ok_o    = out_ok_q;

endmodule

### rtl/core/mersenne_twister_generator.sv
// MT19937 generator: a next request reads its position and then loads the tempered word into the
// output register, which waits while the previous word is not taken; no new transfer is taken
// until then. A request at the end of the store first regenerates it word by word through the
// states StTwB and StTwC, set by the single read port of the state memory. Key-array seeding
// follows linear seeding and reads, then writes, the state memory in each mixing step.
// Reset (rst_ni, asynchronous, active low) clears the seeded flag and sets the read position
// to the end; the state memory is not cleared and is fully written by every seeding.
module mersenne_twister_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] seed
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] word
  output logic        m_axis_tuser    // [0] ok
);

  mt_pkg::dp_cmd_e    cmd;
  mt_pkg::dp_status_t status;

  // Sequencer.
  mt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Memory and arithmetic.
  mt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_op_i     (s_axis_tuser),
    .in_seed_i   (s_axis_tdata),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_word_o  (m_axis_tdata),
    .out_ok_o    (m_axis_tuser)
  );

endmodule

### sim/testbench.sv
// Testbench of the MT19937 generator: table-driven and random requests checked against a predictor.
`timescale 1ns / 100ps

module testbench;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  mersenne_twister_generator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic [31:0] word;
    logic        ok;
  } mt_word_t;

  typedef struct {
    logic [1:0]  op;
    logic [63:0] seed;
    logic        fixed;   // the expected word below is known outright
    mt_word_t    word;
  } stim_row_t;

  // Predictor state.
  logic [31:0] gen_store [mt_pkg::NumWords];
  int unsigned gen_pos;
  bit          gen_seeded;
  mt_word_t    pending_words [$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned out_gap;

  // Clock.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void gen_linear(input logic [31:0] s);
    logic [31:0] p;
    gen_store[0] = s;
    for (int i = 1; i < mt_pkg::NumWords; i++) begin
      p = gen_store[i-1];
      gen_store[i] = 32'd1812433253 * (p ^ (p >> 30)) + 32'(i);
    end
    gen_pos = mt_pkg::NumWords;
  endfunction

  function automatic void gen_key(input logic [63:0] s);
    logic [31:0] key [2];
    logic [31:0] p;
    int unsigned klen, i, j;
    key[0] = s[31:0];
    key[1] = s[63:32];
    klen = (s[63:32] != 0) ? 2 : 1;
    i = 1;
    j = 0;
    gen_linear(32'd19650218);
    for (int k = mt_pkg::NumWords; k > 0; k--) begin
      p = gen_store[i-1];
      gen_store[i] = (gen_store[i] ^ ((p ^ (p >> 30)) * 32'd1664525)) + key[j & 1] + 32'(j);
      i++;
      j++;
      if (i >= mt_pkg::NumWords) begin
        gen_store[0] = gen_store[mt_pkg::NumWords-1];
        i = 1;
      end
      if (j >= klen) j = 0;
    end
    for (int k = mt_pkg::NumWords - 1; k > 0; k--) begin
      p = gen_store[i-1];
      gen_store[i] = (gen_store[i] ^ ((p ^ (p >> 30)) * 32'd1566083941)) - 32'(i);
      i++;
      if (i >= mt_pkg::NumWords) begin
        gen_store[0] = gen_store[mt_pkg::NumWords-1];
        i = 1;
      end
    end
    gen_store[0] = 32'h80000000;
    gen_pos = mt_pkg::NumWords;
  endfunction

  // Applies one request to the predictor and queues the word it yields, if any.
  function automatic void predict_request(input logic [1:0] op, input logic [63:0] s);
    logic [31:0] y, n;
    mt_word_t w;
    case (op)
      mt_pkg::OpSeedLin: begin
        gen_linear(s[31:0]);
        gen_seeded = 1'b1;
      end
      mt_pkg::OpSeedKey: begin
        gen_key(s);
        gen_seeded = 1'b1;
      end
      mt_pkg::OpNext: begin
        if (!gen_seeded) begin
          w = '{word: 32'd0, ok: 1'b0};
        end else begin
          if (gen_pos >= mt_pkg::NumWords) begin
            for (int i = 0; i < mt_pkg::NumWords; i++) begin
              y = (gen_store[i] & 32'h80000000) |
                  (gen_store[(i + 1) % mt_pkg::NumWords] & 32'h7fffffff);
              n = gen_store[(i + 397) % mt_pkg::NumWords] ^ (y >> 1);
              if (y[0]) n = n ^ 32'h9908b0df;
              gen_store[i] = n;
            end
            gen_pos = 0;
          end
          y = gen_store[gen_pos];
          y = y ^ (y >> 11);
          y = y ^ ((y << 7) & 32'h9d2c5680);
          y = y ^ ((y << 15) & 32'hefc60000);
          y = y ^ (y >> 18);
          w = '{word: y, ok: 1'b1};
          gen_pos++;
        end
        pending_words.push_back(w);
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(3) == 0) return 0;
    if ($urandom_range(19) == 0) return $urandom_range(40, 8);
    return $urandom_range(3);
  endfunction

  // Sends one request and waits for its transfer.
  task automatic send_request(input logic [1:0] op, input logic [63:0] s);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= s;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_request(op, s);
  endtask

  task automatic send_with_gap(input logic [1:0] op, input logic [63:0] s);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    send_request(op, s);
  endtask

  // Receiver stalls: after each transfer the receiver pauses for a random gap, which may be zero.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      out_gap = pick_gap();
    end else if (out_gap != 0) begin
      m_axis_tready <= 1'b0;
      out_gap--;
    end else begin
      m_axis_tready <= 1'b1;
      if (m_axis_tvalid && m_axis_tready) out_gap = pick_gap();
    end
  end

  // Output checking.
  always @(posedge clk_i) begin
    mt_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word %h ok %b", $time, m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        want = pending_words.pop_front();
        if (m_axis_tdata !== want.word) begin
          $display("%0t: word expected %h actual %h", $time, want.word, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tuser !== want.ok) begin
          $display("%0t: ok expected %b actual %b", $time, want.ok, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  stim_row_t directed [] = '{
    '{mt_pkg::OpNext,    64'h0, 1'b1, '{32'd0, 1'b0}},          // next before any seed
    '{OpUnused,          64'hffff_ffff_ffff_ffff, 1'b0, '0},    // unused code is ignored
    '{mt_pkg::OpNext,    64'hffff_ffff_ffff_ffff, 1'b1, '{32'd0, 1'b0}},
    '{mt_pkg::OpSeedLin, 64'd5489, 1'b0, '0},                   // default seed
    '{mt_pkg::OpNext,    64'h0, 1'b1, '{32'd3499211612, 1'b1}},
    '{mt_pkg::OpNext,    64'h0, 1'b1, '{32'd581869302, 1'b1}},
    '{mt_pkg::OpSeedLin, 64'h0, 1'b0, '0},
    '{mt_pkg::OpNext,    64'h0, 1'b0, '0},
    '{mt_pkg::OpSeedLin, 64'hffff_ffff_ffff_ffff, 1'b0, '0},
    '{mt_pkg::OpNext,    64'h0, 1'b0, '0},
    '{mt_pkg::OpSeedKey, 64'h0, 1'b0, '0},                      // one-word key of zero
    '{mt_pkg::OpNext,    64'h0, 1'b0, '0},
    '{mt_pkg::OpSeedKey, 64'hffff_ffff_ffff_ffff, 1'b0, '0},    // two-word key
    '{mt_pkg::OpNext,    64'h0, 1'b0, '0},
    '{OpUnused,          64'h0, 1'b0, '0},
    '{mt_pkg::OpNext,    64'h0, 1'b0, '0},
    '{mt_pkg::OpSeedKey, 64'h0000_0001_0000_0000, 1'b0, '0},
    '{mt_pkg::OpNext,    64'h0, 1'b0, '0},
    '{mt_pkg::OpSeedKey, 64'h0000_0000_1234_5678, 1'b0, '0},
    '{mt_pkg::OpNext,    64'h0, 1'b0, '0}
  };

  initial begin
    logic [1:0]  op;
    logic [63:0] s;
    int unsigned pick;
    int unsigned sent;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = mt_pkg::OpNext;
    gen_pos       = mt_pkg::NumWords;
    gen_seeded    = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    foreach (directed[r]) begin
      send_with_gap(directed[r].op, directed[r].seed);
      if (directed[r].fixed && directed[r].op == mt_pkg::OpNext)
        pending_words[pending_words.size()-1] = directed[r].word;
    end

    // Random part: mostly next requests, runs long enough to cross regenerations.
    sent = 0;
    while (sent < 1150) begin
      pick = $urandom_range(999);
      s = {$urandom(), $urandom()};
      if (pick < 6) op = mt_pkg::OpSeedLin;
      else if (pick < 10) begin
        op = mt_pkg::OpSeedKey;
        if ($urandom_range(1) == 0) s[63:32] = '0;
      end else if (pick < 20) op = OpUnused;
      else op = mt_pkg::OpNext;
      send_with_gap(op, s);
      if (op != OpUnused) sent++;
    end
    s_axis_tvalid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending_words.size() == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

### files.f
rtl/core/mt_pkg.sv
rtl/core/mt_ctrl.sv
rtl/core/mt_dp.sv
rtl/core/mersenne_twister_generator.sv
sim/testbench.sv
